>>> rtl/core/wavhdr_pkg.sv
// ----------------------------------------------------------------------------
// wavhdr_pkg
// shared tags, status codes, result layout and helpers for the wav header parser
// ----------------------------------------------------------------------------
package wavhdr_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  localparam logic [32:0] FMT_MIN_SIZE = 33'd16;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd1;
  localparam logic [2:0] ST_FMT_SMALL   = 3'd2;
  localparam logic [2:0] ST_FMT_TRUNC   = 3'd3;
  localparam logic [2:0] ST_MISSING     = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd5;
  localparam logic [2:0] ST_ZERO_FRAME  = 3'd6;

  localparam int OFFSET_BITS = 36;
  localparam int BPF_BITS    = 29;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  // fields from the lowest bit up: status first
  typedef struct packed {
    logic                   pad;
    logic [31:0]            frame_count;
    logic [OFFSET_BITS-1:0] data_offset;
    logic [31:0]            data_bytes;
    logic [15:0]            bits_per_sample;
    logic [31:0]            sample_rate;
    logic [15:0]            channel_count;
    logic [15:0]            audio_format;
    logic [2:0]             status;
  } result_t;

  // little-endian size field sits byte-reversed in the header shifter
  function automatic logic [31:0] swap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

>>> rtl/core/wav_header_chunk_parser.sv
// ----------------------------------------------------------------------------
// wav_header_chunk_parser
// streams a riff/wave file, captures the fmt and data chunk fields, reports them
// ----------------------------------------------------------------------------
// Input channel s_axis: one file byte per item in tdata, tlast on the final byte.
// Bytes are taken one per cycle while the block is parsing; the chunk walk,
// field capture and offset count all update in the same cycle as the byte.
// On the item with tlast the fields are checked and one result item leaves on
// m_axis. When the status is ok, the multiply state builds the frame size on a single
// 16x13 multiplier and a shared restoring divider then works out data size /
// frame size, so the result is valid once the divide state is done; an error
// status is valid on the cycle after the last byte.
// s_axis_tready stays low from the last byte until the result item is taken,
// so a stalled receiver holds the result and stops the next file.
// Reset clears the parse state and the control state; no result is pending.
// The parse state also returns to its reset values at every final byte.
// ----------------------------------------------------------------------------
module wav_header_chunk_parser #(
  parameter int POSITION_BITS = 36
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // file_byte
  input  logic         s_axis_tlast,   // end_of_file
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [183:0] m_axis_tdata    // status, audio_format, channel_count,
                                       // sample_rate, bits_per_sample, data_bytes,
                                       // data_offset, frame_count, zero pad
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_CHUNK  = 3'd1;
  localparam logic [2:0] PH_FMT    = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_DEAD   = 3'd4;

  localparam logic [1:0] CTL_RUN = 2'd0;
  localparam logic [1:0] CTL_MUL = 2'd1;
  localparam logic [1:0] CTL_DIV = 2'd2;
  localparam logic [1:0] CTL_OUT = 2'd3;

  localparam logic [32:0] LEFT_FILE_HDR  = 33'd12;
  localparam logic [32:0] LEFT_CHUNK_HDR = 33'd8;

  localparam int OB = wavhdr_pkg::OFFSET_BITS;
  localparam int CB = wavhdr_pkg::DIV_CNT_BITS;

  // parse state
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [2:0]               parse_phase, parse_phase_next;
  logic [63:0]              header_shift, header_shift_next;
  logic [32:0]              bytes_left, bytes_left_next;
  logic [2:0]               latched_error, latched_error_next;
  logic [15:0]              format_tag, format_tag_next;
  logic [15:0]              channels, channels_next;
  logic [31:0]              rate, rate_next;
  logic [15:0]              depth, depth_next;
  logic [31:0]              data_size, data_size_next;
  logic [OB-1:0]            data_start, data_start_next;
  logic [1:0]               found_flags, found_flags_next;

  // control and shared divider
  logic [1:0]                          ctl;
  logic [CB-1:0]                       div_cnt;
  logic [wavhdr_pkg::BPF_BITS-1:0]     bpf;
  logic [31:0]                         rem;
  wavhdr_pkg::result_t                 result;

  logic        accept;
  logic        last_accept;
  logic [63:0] shift_in;
  logic [32:0] left_dec;
  logic [31:0] chunk_id;
  logic [31:0] chunk_size;
  logic [32:0] chunk_span;
  logic [31:0] fmt_size;
  logic [32:0] fmt_idx;
  logic [2:0]  final_status;
  logic [31:0] rem_sh;
  logic [32:0] trial;

  assign s_axis_tready = (ctl == CTL_RUN);
  assign m_axis_tvalid = (ctl == CTL_OUT);
  assign m_axis_tdata  = result;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last_accept   = accept && s_axis_tlast;

  assign shift_in   = {header_shift[55:0], s_axis_tdata};
  assign left_dec   = bytes_left - 33'd1;
  assign chunk_id   = shift_in[63:32];
  assign chunk_size = wavhdr_pkg::swap32(shift_in[31:0]);
  assign chunk_span = {1'b0, chunk_size} + {32'd0, chunk_size[0]};
  assign fmt_size   = wavhdr_pkg::swap32(header_shift[31:0]);
  assign fmt_idx    = {1'b0, fmt_size} - bytes_left;

  always_comb begin
    byte_position_next = byte_position;
    parse_phase_next   = parse_phase;
    header_shift_next  = header_shift;
    bytes_left_next    = bytes_left;
    latched_error_next = latched_error;
    format_tag_next    = format_tag;
    channels_next      = channels;
    rate_next          = rate;
    depth_next         = depth;
    data_size_next     = data_size;
    data_start_next    = data_start;
    found_flags_next   = found_flags;

    if (byte_position != '1) begin
      byte_position_next = byte_position + POSITION_BITS'(1);
    end

    unique case (parse_phase)
      PH_HEADER: begin
        header_shift_next = shift_in;
        bytes_left_next   = left_dec;
        if (left_dec == LEFT_CHUNK_HDR && shift_in[31:0] != wavhdr_pkg::TAG_RIFF) begin
          latched_error_next = wavhdr_pkg::ST_BAD_HEADER;
          parse_phase_next   = PH_DEAD;
        end else if (left_dec == 33'd0) begin
          if (shift_in[31:0] != wavhdr_pkg::TAG_WAVE) begin
            latched_error_next = wavhdr_pkg::ST_BAD_HEADER;
            parse_phase_next   = PH_DEAD;
          end else begin
            parse_phase_next = PH_CHUNK;
            bytes_left_next  = LEFT_CHUNK_HDR;
          end
        end
      end
      PH_CHUNK: begin
        header_shift_next = shift_in;
        bytes_left_next   = left_dec;
        if (left_dec == 33'd0) begin
          if (chunk_id == wavhdr_pkg::TAG_FMT) begin
            if ({1'b0, chunk_size} < wavhdr_pkg::FMT_MIN_SIZE) begin
              latched_error_next = wavhdr_pkg::ST_FMT_SMALL;
              parse_phase_next   = PH_DEAD;
            end else begin
              parse_phase_next = PH_FMT;
              bytes_left_next  = {1'b0, chunk_size};
            end
          end else begin
            if (chunk_id == wavhdr_pkg::TAG_DATA) begin
              data_size_next   = chunk_size;
              data_start_next  = OB'(byte_position_next);
              found_flags_next = found_flags | 2'b10;
            end
            // zero-size chunk: the next header follows at once
            if (chunk_span == 33'd0) begin
              parse_phase_next = PH_CHUNK;
              bytes_left_next  = LEFT_CHUNK_HDR;
            end else begin
              parse_phase_next = PH_SKIP;
              bytes_left_next  = chunk_span;
            end
          end
        end
      end
      PH_FMT: begin
        if (fmt_idx < 33'd2) begin
          format_tag_next[{fmt_idx[0], 3'b000} +: 8] = s_axis_tdata;
        end else if (fmt_idx < 33'd4) begin
          channels_next[{fmt_idx[0], 3'b000} +: 8] = s_axis_tdata;
        end else if (fmt_idx < 33'd8) begin
          rate_next[{fmt_idx[1:0], 3'b000} +: 8] = s_axis_tdata;
        end else if (fmt_idx == 33'd14 || fmt_idx == 33'd15) begin
          depth_next[{fmt_idx[0], 3'b000} +: 8] = s_axis_tdata;
        end
        bytes_left_next = left_dec;
        if (left_dec == 33'd0) begin
          found_flags_next = found_flags | 2'b01;
          if (fmt_size[0]) begin
            parse_phase_next = PH_SKIP;
            bytes_left_next  = 33'd1;
          end else begin
            parse_phase_next = PH_CHUNK;
            bytes_left_next  = LEFT_CHUNK_HDR;
          end
        end
      end
      PH_SKIP: begin
        bytes_left_next = left_dec;
        if (left_dec == 33'd0) begin
          parse_phase_next = PH_CHUNK;
          bytes_left_next  = LEFT_CHUNK_HDR;
        end
      end
      default: begin
      end
    endcase
  end

  // checks on the state as it stands after the final byte
  always_comb begin
    final_status = latched_error_next;
    if (final_status == wavhdr_pkg::ST_OK) begin
      if (parse_phase_next == PH_HEADER) begin
        final_status = wavhdr_pkg::ST_BAD_HEADER;
      end else if (parse_phase_next == PH_FMT) begin
        final_status = wavhdr_pkg::ST_FMT_TRUNC;
      end else if (found_flags_next != 2'b11 || channels_next == 16'd0 ||
                   rate_next == 32'd0 || depth_next == 16'd0) begin
        final_status = wavhdr_pkg::ST_MISSING;
      end else if (format_tag_next != wavhdr_pkg::FMT_PCM &&
                   format_tag_next != wavhdr_pkg::FMT_FLOAT) begin
        final_status = wavhdr_pkg::ST_UNSUPPORTED;
      end else if (depth_next[15:3] == 13'd0) begin
        final_status = wavhdr_pkg::ST_ZERO_FRAME;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || last_accept) begin
      byte_position <= '0;
      parse_phase   <= PH_HEADER;
      header_shift  <= 64'd0;
      bytes_left    <= LEFT_FILE_HDR;
      latched_error <= wavhdr_pkg::ST_OK;
      format_tag    <= 16'd0;
      channels      <= 16'd0;
      rate          <= 32'd0;
      depth         <= 16'd0;
      data_size     <= 32'd0;
      data_start    <= '0;
      found_flags   <= 2'b00;
    end else if (accept) begin
      byte_position <= byte_position_next;
      parse_phase   <= parse_phase_next;
      header_shift  <= header_shift_next;
      bytes_left    <= bytes_left_next;
      latched_error <= latched_error_next;
      format_tag    <= format_tag_next;
      channels      <= channels_next;
      rate          <= rate_next;
      depth         <= depth_next;
      data_size     <= data_size_next;
      data_start    <= data_start_next;
      found_flags   <= found_flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= CTL_RUN;
    end else begin
      unique case (ctl)
        CTL_RUN: begin
          if (last_accept) begin
            ctl <= (final_status == wavhdr_pkg::ST_OK) ? CTL_MUL : CTL_OUT;
          end
        end
        CTL_MUL: begin
          ctl <= CTL_DIV;
        end
        CTL_DIV: begin
          if (div_cnt == CB'(wavhdr_pkg::DIV_STEPS - 1)) begin
            ctl <= CTL_OUT;
          end
        end
        CTL_OUT: begin
          if (m_axis_tready) begin
            ctl <= CTL_RUN;
          end
        end
        default: begin
          ctl <= CTL_RUN;
        end
      endcase
    end
  end

  // restoring divider: quotient shifts in through frame_count
  assign rem_sh = {rem[30:0], result.frame_count[31]};
  assign trial  = {1'b0, rem_sh} - {4'd0, bpf};

  always_ff @(posedge clk) begin
    case (ctl)
      CTL_RUN: begin
        if (last_accept) begin
          result.pad             <= 1'b0;
          result.status          <= final_status;
          result.audio_format    <= format_tag_next;
          result.channel_count   <= channels_next;
          result.sample_rate     <= rate_next;
          result.bits_per_sample <= depth_next;
          result.data_bytes      <= data_size_next;
          result.data_offset     <= data_start_next;
          result.frame_count     <= 32'd0;
        end
      end
      CTL_MUL: begin
        bpf                <= {13'd0, result.channel_count} *
                              {16'd0, result.bits_per_sample[15:3]};
        rem                <= 32'd0;
        result.frame_count <= result.data_bytes;
        div_cnt            <= '0;
      end
      CTL_DIV: begin
        if (!trial[32]) begin
          rem                <= trial[31:0];
          result.frame_count <= {result.frame_count[30:0], 1'b1};
        end else begin
          rem                <= rem_sh;
          result.frame_count <= {result.frame_count[30:0], 1'b0};
        end
        div_cnt <= div_cnt + CB'(1);
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_one_side_busy: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (ctl == CTL_DIV) |-> (bpf != '0))
    else $error("divider running with zero frame size");

  a_error_no_frames: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result.status != wavhdr_pkg::ST_OK) |-> (result.frame_count == 32'd0))
    else $error("frame count reported with error status");

  a_header_no_error: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_HEADER) |-> (latched_error == wavhdr_pkg::ST_OK))
    else $error("error latched while still in the file header");
`endif

endmodule
